// File: rtl/core/wmdu_pkg.sv
package wmdu_pkg;

   typedef enum logic [1:0] {
      OP_MULU = 2'd0,
      OP_MULS = 2'd1,
      OP_DIVU = 2'd2,
      OP_DIVS = 2'd3
   } op_type;

   localparam int FLAG_X = 4;
   localparam int FLAG_N = 3;
   localparam int FLAG_Z = 2;
   localparam int FLAG_V = 1;
   localparam int FLAG_C = 0;

   localparam int NumDivStages = 16;
   localparam int BitsPerStage = 2;

   typedef struct packed {
      logic        is_div;
      logic        is_signed;
      logic        dz;
      logic        qneg;
      logic        rneg;
      logic [4:0]  flags;
   } ctl_type;

   typedef struct packed {
      logic [16:0] rem;
      logic [31:0] quo;
      logic [15:0] dvs;
   } div_type;

endpackage

// File: rtl/core/wmdu_div_stage.sv
module wmdu_div_stage
   import wmdu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    valid_in,
   input  ctl_type ctl_in,
   input  div_type div_in,
   input  logic [31:0] prod_in,
   output logic    valid_out,
   output ctl_type ctl_out,
   output div_type div_out,
   output logic [31:0] prod_out
);

   logic    valid_ff;
   ctl_type ctl_ff;
   div_type div_ff;
   logic [31:0] prod_ff;
   div_type div_in_c;

   always_comb begin
      logic [16:0] r;
      logic [31:0] q;
      logic [16:0] t;
      r = div_in.rem;
      q = div_in.quo;
      t = '0;
      for (int i = 0; i < BitsPerStage; i++) begin
         r = {r[15:0], q[31]};
         q = {q[30:0], 1'b0};
         t = r - {1'b0, div_in.dvs};
         if (!t[16]) begin
            r = t;
            q[0] = 1'b1;
         end
      end
      div_in_c.rem = r;
      div_in_c.quo = q;
      div_in_c.dvs = div_in.dvs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      ctl_ff  <= ctl_in;
      div_ff  <= div_in_c;
      prod_ff <= prod_in;
   end

   assign valid_out = valid_ff;
   assign ctl_out   = ctl_ff;
   assign div_out   = div_ff;
   assign prod_out  = prod_ff;

endmodule

// File: rtl/core/word_multiply_divide_unit_top.sv
// Throughput is one beat per cycle from start to rsp_valid.
// Stages: operand magnitudes, multiply product (divide operands passed through),
// 16 divider stages of two quotient bits each (product carried alongside), result and flags.
// busy is always low; the receiver cannot stall, so nothing backs up.
// reset (synchronous) clears all valid bits; payload registers are not reset.
module word_multiply_divide_unit_top
   import wmdu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_dest_value,
   input  logic [15:0] req_source_word,
   input  logic [4:0]  req_flags_in,
   output logic        rsp_valid,
   output logic [31:0] rsp_result_value,
   output logic        rsp_write_enable,
   output logic [4:0]  rsp_flags_out,
   output logic        rsp_divide_by_zero
);

   logic        s0_valid_ff;
   ctl_type     s0_ctl_ff;
   div_type     s0_div_ff;
   logic [16:0] s0_ma_ff, s0_mb_ff;
   logic        s0_pneg_ff;

   logic        s1_valid_ff;
   ctl_type     s1_ctl_ff;
   div_type     s1_div_ff;
   logic [31:0] s1_prod_ff;

   logic        v_w [NumDivStages+1];
   ctl_type     c_w [NumDivStages+1];
   div_type     d_w [NumDivStages+1];
   logic [31:0] p_w [NumDivStages+1];

   logic        out_valid_ff;
   logic [31:0] out_res_ff;
   logic        out_we_ff;
   logic [4:0]  out_fl_ff;
   logic        out_dz_ff;

   op_type      op_c;
   ctl_type     ctl_c;
   div_type     div_c;
   logic        na_c, nb_c, sd_c, sv_c;
   logic [16:0] ma_c, mb_c;
   logic [31:0] md_c;
   logic [15:0] mv_c;

   assign busy = 1'b0;

   always_comb begin
      op_c = op_type'(req_opcode);
      na_c = req_dest_value[15];
      nb_c = req_source_word[15];
      sd_c = req_dest_value[31];
      sv_c = req_source_word[15];
      ma_c = {1'b0, req_dest_value[15:0]};
      mb_c = {1'b0, req_source_word};
      md_c = req_dest_value;
      mv_c = req_source_word;
      if (op_c == OP_MULS) begin
         if (na_c) ma_c = 17'h10000 - {1'b0, req_dest_value[15:0]};
         if (nb_c) mb_c = 17'h10000 - {1'b0, req_source_word};
      end
      if (op_c == OP_DIVS) begin
         if (sd_c) md_c = 32'd0 - req_dest_value;
         if (sv_c) mv_c = 16'd0 - req_source_word;
      end
      ctl_c.is_div    = req_opcode[1];
      ctl_c.is_signed = req_opcode[0];
      ctl_c.dz        = req_opcode[1] && (req_source_word == 16'd0);
      ctl_c.qneg      = (op_c == OP_DIVS) && (sd_c != sv_c);
      ctl_c.rneg      = (op_c == OP_DIVS) && sd_c;
      ctl_c.flags     = req_flags_in;
      div_c.rem = '0;
      div_c.quo = md_c;
      div_c.dvs = mv_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start;
         s1_valid_ff <= s0_valid_ff;
      end
      s0_ctl_ff  <= ctl_c;
      s0_div_ff  <= div_c;
      s0_ma_ff   <= ma_c;
      s0_mb_ff   <= mb_c;
      s0_pneg_ff <= (op_c == OP_MULS) && (na_c != nb_c);
      s1_ctl_ff  <= s0_ctl_ff;
      s1_div_ff  <= s0_div_ff;
      s1_prod_ff <= s0_pneg_ff ? 32'd0 - 32'(s0_ma_ff * s0_mb_ff)
                               : 32'(s0_ma_ff * s0_mb_ff);
   end

   assign v_w[0] = s1_valid_ff;
   assign c_w[0] = s1_ctl_ff;
   assign d_w[0] = s1_div_ff;
   assign p_w[0] = s1_prod_ff;

   for (genvar g = 0; g < NumDivStages; g++) begin : g_div
      wmdu_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (v_w[g]),
         .ctl_in    (c_w[g]),
         .div_in    (d_w[g]),
         .prod_in   (p_w[g]),
         .valid_out (v_w[g+1]),
         .ctl_out   (c_w[g+1]),
         .div_out   (d_w[g+1]),
         .prod_out  (p_w[g+1])
      );
   end

   ctl_type     fc;
   logic [31:0] fq, fp;
   logic [15:0] fr, qw, rw;
   logic        ovf;
   logic [31:0] res_c;
   logic        we_c;
   logic [4:0]  fl_c;

   always_comb begin
      fc  = c_w[NumDivStages];
      fq  = d_w[NumDivStages].quo;
      fr  = d_w[NumDivStages].rem[15:0];
      fp  = p_w[NumDivStages];
      qw  = fc.qneg ? 16'd0 - fq[15:0] : fq[15:0];
      rw  = fc.rneg ? 16'd0 - fr : fr;
      if (!fc.is_signed) begin
         ovf = fq[31:16] != 16'd0;
      end else if (fc.qneg) begin
         ovf = fq > 32'd32768;
      end else begin
         ovf = fq > 32'd32767;
      end
      res_c = '0;
      we_c  = 1'b0;
      fl_c  = fc.flags;
      if (!fc.is_div) begin
         res_c = fp;
         we_c  = 1'b1;
         fl_c  = {fc.flags[FLAG_X], fp[31], fp == 32'd0, 2'b00};
      end else if (fc.dz) begin
         if (!fc.is_signed) fl_c = {fc.flags[FLAG_X], 4'b0000};
      end else if (ovf) begin
         fl_c[FLAG_V] = 1'b1;
         fl_c[FLAG_C] = 1'b0;
      end else begin
         res_c = {rw, qw};
         we_c  = 1'b1;
         fl_c  = {fc.flags[FLAG_X], qw[15], qw == 16'd0, 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= v_w[NumDivStages];
      end
      out_res_ff <= res_c;
      out_we_ff  <= we_c;
      out_fl_ff  <= fl_c;
      out_dz_ff  <= fc.is_div && fc.dz;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_value   = out_res_ff;
   assign rsp_write_enable   = out_we_ff;
   assign rsp_flags_out      = out_fl_ff;
   assign rsp_divide_by_zero = out_dz_ff;

endmodule
